>>> sv/i2cm_pkg.sv
// shared types and constants of the i2c master bit engine
package i2cm_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned PLEN_W     = 11;
  localparam int unsigned DIV_W      = 10;
  localparam int unsigned BITCNT_W   = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [PLEN_W-1:0]    PLEN_RST        = 11'd1;
  localparam logic [PLEN_W-1:0]    PLEN_MIN        = 11'd1;
  localparam logic [PLEN_W-1:0]    PLEN_MAX        = 11'd1024;
  localparam logic [BYTE_W-1:0]    MSB_MASK        = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PHASE = 4'd1;

  // op codes on the tick channel
  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_WAIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT,
    CMD_STOP
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_SDA_HI = 5'd1,
    PH_ST_SCL_HI = 5'd2,
    PH_ST_SDA_LO = 5'd3,
    PH_ST_SCL_LO = 5'd4,
    PH_WR_PRE    = 5'd5,
    PH_WR_DATA   = 5'd6,
    PH_WR_HIGH   = 5'd7,
    PH_WR_LOW    = 5'd8,
    PH_RD_HIGH   = 5'd9,
    PH_RD_LOW    = 5'd10,
    PH_AK_PRE    = 5'd11,
    PH_AK_DATA   = 5'd12,
    PH_AK_HIGH   = 5'd13,
    PH_AK_LOW    = 5'd14,
    PH_WT_REL    = 5'd15,
    PH_WT_POLL   = 5'd16,
    PH_SP_LOW    = 5'd17,
    PH_SP_HIGH   = 5'd18,
    PH_SP_SDA_HI = 5'd19
  } phase_e;

  // classified tick as held in the queue
  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] write_data;
    logic              send_ack;
    logic              sda_in;
  } tick_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_error;
  } res_t;

endpackage

>>> sv/i2cm_ifs.sv
// channel interfaces: tick input, result output and configuration write
interface i2cm_tick_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd_valid;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] write_data;
  logic              send_ack;
  logic              sda_in;
  modport source (output valid, cmd_valid, op, write_data, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, op, write_data, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;
  logic              ack_error;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, ack_error,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data, ack_error,
                  output ready);
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/i2cm_front.sv
// front end: accepts ticks and classifies the command they carry
module i2cm_front (
  i2cm_tick_if.sink      tick_i,
  input  logic           q_ready_i,
  output logic           q_valid_o,
  output i2cm_pkg::tick_t q_item_o
);
  import i2cm_pkg::*;

  cmd_e cmd;

  always_comb begin
    cmd = CMD_NONE;
    if (tick_i.cmd_valid) begin
      case (tick_i.op)
        OP_START: cmd = CMD_START;
        OP_WRITE: cmd = CMD_WRITE;
        OP_READ:  cmd = CMD_READ;
        OP_WAIT:  cmd = CMD_WAIT;
        OP_STOP:  cmd = CMD_STOP;
        default:  cmd = CMD_NONE;  // unknown ops are dropped
      endcase
    end
  end

  assign q_valid_o           = tick_i.valid;
  assign tick_i.ready        = q_ready_i;
  assign q_item_o.cmd        = cmd;
  assign q_item_o.write_data = tick_i.write_data;
  assign q_item_o.send_ack   = tick_i.send_ack;
  assign q_item_o.sda_in     = tick_i.sda_in;

endmodule

>>> sv/i2cm_queue.sv
// short queue of classified ticks between front and back
module i2cm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  i2cm_pkg::tick_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output i2cm_pkg::tick_t pop_item_o
);
  import i2cm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tick_t            entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/i2cm_back.sv
// back end: bus phase sequencer, configuration registers and result register
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  i2cm_pkg::tick_t q_item_i,
  i2cm_cfg_if.sink        cfg_i,
  i2cm_res_if.source      res_o
);
  import i2cm_pkg::*;

  // configuration
  logic [TIMEOUT_W-1:0] ack_timeout_q;
  logic [PLEN_W-1:0]    ticks_phase_q;

  // sequencer state
  phase_e               phase_q, phase_d;
  logic [BITCNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [BYTE_W-1:0]    shreg_q, shreg_d;
  logic                 ack_choice_q, ack_choice_d;
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic [BYTE_W-1:0]    held_read_q, held_read_d;

  // result register
  res_t                 res_q, res_d;
  logic                 res_valid_q;

  logic [PLEN_W-1:0]    plen;
  logic [PLEN_W-1:0]    div_next;
  logic                 advance;
  logic                 step;
  logic                 enter;
  phase_e               enter_ph;
  logic                 done;
  logic                 err;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
      ticks_phase_q <= PLEN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_i.data;
        CFG_TICKS_PHASE: ticks_phase_q <= cfg_i.data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ticks_phase_q < PLEN_MIN) begin
      plen = PLEN_MIN;
    end else if (ticks_phase_q > PLEN_MAX) begin
      plen = PLEN_MAX;
    end else begin
      plen = ticks_phase_q;
    end
  end

  assign div_next = {1'b0, div_q} + 1'b1;

  // one tick of the sequencer
  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shreg_d      = shreg_q;
    ack_choice_d = ack_choice_q;
    timeout_d    = timeout_q;
    div_d        = div_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    held_read_d  = held_read_q;
    enter        = 1'b0;
    enter_ph     = PH_IDLE;
    done         = 1'b0;
    err          = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (q_item_i.cmd != CMD_NONE) begin
        bit_cnt_d = '0;
        enter     = 1'b1;
      end
      case (q_item_i.cmd)
        CMD_START: enter_ph = PH_ST_SDA_HI;
        CMD_WRITE: begin
          shreg_d  = q_item_i.write_data;
          enter_ph = PH_WR_PRE;
        end
        CMD_READ: begin
          shreg_d      = '0;
          ack_choice_d = q_item_i.send_ack;
          enter_ph     = PH_RD_HIGH;
        end
        CMD_WAIT: begin
          timeout_d = ack_timeout_q;
          enter_ph  = PH_WT_REL;
        end
        CMD_STOP: enter_ph = PH_SP_LOW;
        default:  enter_ph = PH_IDLE;
      endcase
    end else if (phase_q == PH_WT_POLL) begin
      if (!q_item_i.sda_in) begin
        scl_d = 1'b0;
        done  = 1'b1;
      end else if (timeout_q == '0) begin
        scl_d = 1'b0;
        done  = 1'b1;
        err   = 1'b1;
      end else begin
        timeout_d = timeout_q - 1'b1;
      end
    end else if (div_next < plen) begin
      div_d = div_next[DIV_W-1:0];
    end else begin
      // phase has run its length
      enter = 1'b1;
      case (phase_q)
        PH_ST_SDA_HI: enter_ph = PH_ST_SCL_HI;
        PH_ST_SCL_HI: enter_ph = PH_ST_SDA_LO;
        PH_ST_SDA_LO: enter_ph = PH_ST_SCL_LO;
        PH_WR_PRE: begin
          bit_cnt_d = '0;
          enter_ph  = PH_WR_DATA;
        end
        PH_WR_DATA: enter_ph = PH_WR_HIGH;
        PH_WR_HIGH: enter_ph = PH_WR_LOW;
        PH_WR_LOW: begin
          shreg_d   = {shreg_q[BYTE_W-2:0], 1'b0};
          bit_cnt_d = bit_cnt_q + 1'b1;
          if (bit_cnt_d[BITCNT_W-1]) begin
            enter = 1'b0;
            done  = 1'b1;
          end else begin
            enter_ph = PH_WR_DATA;
          end
        end
        PH_RD_HIGH: begin
          shreg_d  = {shreg_q[BYTE_W-2:0], q_item_i.sda_in};
          enter_ph = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          bit_cnt_d = bit_cnt_q + 1'b1;
          enter_ph  = bit_cnt_d[BITCNT_W-1] ? PH_AK_PRE : PH_RD_HIGH;
        end
        PH_AK_PRE:  enter_ph = PH_AK_DATA;
        PH_AK_DATA: enter_ph = PH_AK_HIGH;
        PH_AK_HIGH: enter_ph = PH_AK_LOW;
        PH_AK_LOW: begin
          held_read_d = shreg_q;
          enter       = 1'b0;
          done        = 1'b1;
        end
        PH_WT_REL:  enter_ph = PH_WT_POLL;
        PH_SP_LOW:  enter_ph = PH_SP_HIGH;
        PH_SP_HIGH: enter_ph = PH_SP_SDA_HI;
        default: begin
          enter = 1'b0;
          done  = 1'b1;
        end
      endcase
    end

    // line levels set on phase entry
    if (enter) begin
      phase_d = enter_ph;
      div_d   = '0;
      case (enter_ph)
        PH_ST_SDA_HI: sda_d = 1'b1;
        PH_ST_SCL_HI: scl_d = 1'b1;
        PH_ST_SDA_LO: sda_d = 1'b0;
        PH_ST_SCL_LO: scl_d = 1'b0;
        PH_WR_PRE:    scl_d = 1'b0;
        PH_WR_DATA:   sda_d = ((shreg_d & MSB_MASK) != '0);
        PH_WR_HIGH:   scl_d = 1'b1;
        PH_WR_LOW:    scl_d = 1'b0;
        PH_RD_HIGH: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        PH_RD_LOW:    scl_d = 1'b0;
        PH_AK_PRE:    scl_d = 1'b0;
        PH_AK_DATA:   sda_d = !ack_choice_d;
        PH_AK_HIGH:   scl_d = 1'b1;
        PH_AK_LOW:    scl_d = 1'b0;
        PH_WT_REL:    sda_d = 1'b1;
        PH_WT_POLL:   scl_d = 1'b1;
        PH_SP_LOW: begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        PH_SP_HIGH:   scl_d = 1'b1;
        PH_SP_SDA_HI: sda_d = 1'b1;
        default: ;
      endcase
    end

    if (done) begin
      phase_d = PH_IDLE;
      div_d   = '0;
    end

    res_d.scl_out   = scl_d;
    res_d.sda_out   = sda_d;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.read_data = held_read_d;
    res_d.ack_error = err;
  end

  // the result register frees up whenever it is empty or being taken
  assign advance   = !res_valid_q || res_o.ready;
  assign q_ready_o = advance;
  assign step      = advance && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= '0;
      shreg_q      <= '0;
      ack_choice_q <= 1'b0;
      timeout_q    <= '0;
      div_q        <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      held_read_q  <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (step) begin
        phase_q      <= phase_d;
        bit_cnt_q    <= bit_cnt_d;
        shreg_q      <= shreg_d;
        ack_choice_q <= ack_choice_d;
        timeout_q    <= timeout_d;
        div_q        <= div_d;
        scl_q        <= scl_d;
        sda_q        <= sda_d;
        held_read_q  <= held_read_d;
      end
      if (advance) begin
        res_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.scl_out   = res_q.scl_out;
  assign res_o.sda_out   = res_q.sda_out;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.read_data = res_q.read_data;
  assign res_o.ack_error = res_q.ack_error;

endmodule

>>> sv/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: front, tick queue and sequencer
// Open-drain I2C master sequencer driven one time tick per item. Every tick
// item carries the sampled SDA level and, while the engine is idle, may carry
// a command (start, write byte, read byte with ACK or NACK, wait for ACK,
// stop); each tick returns exactly one result item with the SCL/SDA drive,
// busy, done, the last read byte and the ACK-timeout flag. The engine takes
// one tick every clock cycle as long as results are taken: the sequencer
// step is combinational logic, so throughput is one item per cycle, and
// each tick is registered in the tick queue and then in the result
// register. When the result side stalls, the queue absorbs up to
// QUEUE_DEPTH ticks before the input stalls too. Configuration writes take
// effect at once and are always accepted; index 0 is the ACK poll budget and
// index 1 the ticks per bus phase, clamped to the range 1 to 1024.
module i2c_master_bit_engine #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_tick_if.sink  tick_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_res_if.source res_o
);
  import i2cm_pkg::*;

  // front to queue
  logic  push_valid;
  logic  push_ready;
  tick_t push_item;

  // queue to sequencer
  logic  pop_valid;
  logic  pop_ready;
  tick_t pop_item;

  // classify ticks as they come in
  i2cm_front u_front (
    .tick_i    (tick_i),
    .q_ready_i (push_ready),
    .q_valid_o (push_valid),
    .q_item_o  (push_item)
  );

  // decouples intake from a stalled result side
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // bus phase sequencer with its result register
  i2cm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_item_i  (pop_item),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

endmodule
